// ----- rtl/fisr_pkg.sv -----
// Shared constants, types and helper functions for the approximate square root pipeline.
`default_nettype none

package fisr_pkg;

  // Seed constant and single-precision literals used by the datapath
  localparam logic [31:0] SEED_MAGIC        = 32'h5F3759DF;
  localparam logic [31:0] HALF_BITS         = 32'h3F000000;
  localparam logic [31:0] THREE_HALVES_BITS = 32'h3FC00000;
  localparam logic [31:0] CANON_NAN         = 32'h7FC00000;

  // Latency of one float operator and of one Newton refinement (four operators)
  localparam int unsigned OP_LAT   = 3;
  localparam int unsigned STEP_LAT = 4 * OP_LAT;

  // Operands that travel alongside one refinement
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] half;
    logic [31:0] y;
  } item_t;

  // Leading zero count of a 48-bit word, 48 when all zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fisr_fmul.sv -----
// Three-stage IEEE single multiplier, round to nearest even, full subnormal support.
`default_nettype none

module fisr_fmul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             valid_o,
  output logic [31:0]      p_o
);

  // Stage 1: decode and multiply significands
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [9:0]  eae, ebe;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    ma     = {ea != 8'd0, a_i[22:0]};
    mb     = {eb != 8'd0, b_i[22:0]};
    a_zero = (ea == 8'd0) && (a_i[22:0] == 23'd0);
    b_zero = (eb == 8'd0) && (b_i[22:0] == 23'd0);
    a_inf  = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (b_i[22:0] == 23'd0);
    a_nan  = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
    eae    = (ea == 8'd0) ? 10'd1 : {2'b00, ea};
    ebe    = (eb == 8'd0) ? 10'd1 : {2'b00, eb};
  end

  logic               v1_q, v2_q, v3_q;
  logic               s1_sign_q, s1_nan_q, s1_inf_q, s1_zero_q;
  logic [47:0]        s1_prod_q;
  logic signed [9:0]  s1_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sign_q <= a_i[31] ^ b_i[31];
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    s1_inf_q  <= a_inf | b_inf;
    s1_zero_q <= a_zero | b_zero;
    s1_prod_q <= ma * mb;
    s1_t_q    <= $signed(eae + ebe - 10'd127);
  end

  // Stage 2: normalize, or denormalize with sticky for tiny results
  logic [5:0]  lz;
  logic [5:0]  rs;
  logic [9:0]  rs_full;
  logic [47:0] m2_d;
  logic        st2_d;
  logic [9:0]  e2_d;

  always_comb begin
    lz      = fisr_pkg::lzc48(s1_prod_q);
    rs_full = 10'(-s1_t_q);
    rs      = (rs_full > 10'd48) ? 6'd48 : rs_full[5:0];
    m2_d    = s1_prod_q;
    st2_d   = 1'b0;
    e2_d    = 10'd0;
    if (s1_t_q < 0) begin
      m2_d  = s1_prod_q >> rs;
      st2_d = (s1_prod_q & ~({48{1'b1}} << rs)) != 48'd0;
    end else if ($signed({4'b0000, lz}) <= s1_t_q) begin
      m2_d = s1_prod_q << lz;
      e2_d = 10'(s1_t_q - $signed({4'b0000, lz}) + 10'sd1);
    end else begin
      m2_d = s1_prod_q << s1_t_q[5:0];
    end
  end

  logic        s2_sign_q, s2_nan_q, s2_inf_q, s2_zero_q, s2_st_q;
  logic [47:0] s2_m_q;
  logic [9:0]  s2_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sign_q <= s1_sign_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_zero_q <= s1_zero_q;
    s2_m_q    <= m2_d;
    s2_st_q   <= st2_d;
    s2_e_q    <= e2_d;
  end

  // Stage 3: round to nearest even and pack; carries ripple into the exponent
  logic [30:0] base, mag;
  logic        guard, sticky, inc;
  logic [31:0] p_d;

  always_comb begin
    base   = {s2_e_q[7:0], s2_m_q[46:24]};
    guard  = s2_m_q[23];
    sticky = (s2_m_q[22:0] != 23'd0) | s2_st_q;
    inc    = guard & (sticky | s2_m_q[24]);
    mag    = base + {30'd0, inc};
    if (s2_nan_q) begin
      p_d = fisr_pkg::CANON_NAN;
    end else if (s2_inf_q || s2_e_q >= 10'd255) begin
      p_d = {s2_sign_q, 8'hFF, 23'd0};
    end else if (s2_zero_q) begin
      p_d = {s2_sign_q, 31'd0};
    end else begin
      p_d = {s2_sign_q, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end

  assign valid_o = v3_q;

endmodule

`default_nettype wire

// ----- rtl/fisr_fsub.sv -----
// Three-stage IEEE single subtractor a - b, round to nearest even, full subnormal support.
`default_nettype none

module fisr_fsub (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             valid_o,
  output logic [31:0]      d_o
);

  // Stage 1: decode, order by magnitude, align the smaller operand
  logic        sa, sb, swap;
  logic [7:0]  ea, eb, e_big, e_sml;
  logic [23:0] ma, mb, m_big, m_sml;
  logic        a_inf, b_inf, a_nan, b_nan, eff_sub, s_big;
  logic [7:0]  e_gap;
  logic [4:0]  dc;
  logic [26:0] sml_ext, sml_al;
  logic        sml_st;

  always_comb begin
    sa      = a_i[31];
    sb      = ~b_i[31];
    ea      = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb      = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma      = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb      = {b_i[30:23] != 8'd0, b_i[22:0]};
    a_inf   = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf   = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_nan   = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan   = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    swap    = b_i[30:0] > a_i[30:0];
    e_big   = swap ? eb : ea;
    e_sml   = swap ? ea : eb;
    m_big   = swap ? mb : ma;
    m_sml   = swap ? ma : mb;
    s_big   = swap ? sb : sa;
    eff_sub = sa ^ sb;
    e_gap   = e_big - e_sml;
    dc      = (e_gap > 8'd31) ? 5'd31 : e_gap[4:0];
    sml_ext = {m_sml, 3'b000};
    sml_al  = sml_ext >> dc;
    sml_st  = (sml_ext & ~({27{1'b1}} << dc)) != 27'd0;
    sml_al[0] = sml_al[0] | sml_st;
  end

  logic        v1_q, v2_q, v3_q;
  logic        s1_sign_q, s1_sub_q, s1_nan_q, s1_inf_q;
  logic [26:0] s1_big_q, s1_sml_q;
  logic [7:0]  s1_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sign_q <= s_big;
    s1_sub_q  <= eff_sub;
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & eff_sub);
    s1_inf_q  <= a_inf | b_inf;
    s1_big_q  <= {m_big, 3'b000};
    s1_sml_q  <= sml_al;
    s1_e_q    <= e_big;
  end

  // Stage 2: significand add or subtract
  logic        s2_sign_q, s2_sub_q, s2_nan_q, s2_inf_q;
  logic [27:0] s2_sum_q;
  logic [7:0]  s2_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sign_q <= s1_sign_q;
    s2_sub_q  <= s1_sub_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_e_q    <= s1_e_q;
    s2_sum_q  <= s1_sub_q ? ({1'b0, s1_big_q} - {1'b0, s1_sml_q})
                          : ({1'b0, s1_big_q} + {1'b0, s1_sml_q});
  end

  // Stage 3: normalize, round to nearest even, pack
  logic [5:0]  lz;
  logic [26:0] m;
  logic [8:0]  e_n;
  logic [30:0] base, mag;
  logic        guard, sticky, inc;
  logic [31:0] d_d;

  always_comb begin
    lz  = fisr_pkg::lzc48({s2_sum_q[26:0], 21'h1FFFFF});
    m   = s2_sum_q[26:0];
    e_n = {1'b0, s2_e_q};
    if (s2_sum_q[27]) begin
      m   = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      e_n = {1'b0, s2_e_q} + 9'd1;
    end else if ({2'b00, lz} < s2_e_q) begin
      m   = s2_sum_q[26:0] << lz;
      e_n = {1'b0, s2_e_q} - {3'b000, lz};
    end else begin
      m   = s2_sum_q[26:0] << (s2_e_q - 8'd1);
      e_n = 9'd0;
    end
    base   = {e_n[7:0], m[25:3]};
    guard  = m[2];
    sticky = m[1] | m[0];
    inc    = guard & (sticky | m[3]);
    mag    = base + {30'd0, inc};
    if (s2_nan_q) begin
      d_d = fisr_pkg::CANON_NAN;
    end else if (s2_inf_q || e_n >= 9'd255) begin
      d_d = {s2_sign_q, 8'hFF, 23'd0};
    end else if (s2_sum_q == 28'd0) begin
      d_d = {s2_sign_q & ~s2_sub_q, 31'd0};
    end else begin
      d_d = {s2_sign_q, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_o <= d_d;
  end

  assign valid_o = v3_q;

endmodule

`default_nettype wire

// ----- rtl/fisr_step.sv -----
// One pipelined Newton refinement y' = y * (1.5 - half * y * y).
`default_nettype none

module fisr_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire fisr_pkg::item_t item_i,
  output logic                 valid_o,
  output fisr_pkg::item_t      item_o
);

  localparam int unsigned Lat = fisr_pkg::STEP_LAT;
  localparam int unsigned Op  = fisr_pkg::OP_LAT;

  // Operand delay line, one slot per pipeline cycle
  fisr_pkg::item_t pipe_q [Lat];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < Lat; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  // Operator chain
  logic        v_sq, v_prod, v_diff, v_y;
  logic [31:0] sq, prod, diff, y_new;

  fisr_fmul u_sq (
    .clk_i, .rst_ni, .valid_i(valid_i),
    .a_i(item_i.y), .b_i(item_i.y), .valid_o(v_sq), .p_o(sq)
  );

  fisr_fmul u_prod (
    .clk_i, .rst_ni, .valid_i(v_sq),
    .a_i(pipe_q[Op-1].half), .b_i(sq), .valid_o(v_prod), .p_o(prod)
  );

  fisr_fsub u_diff (
    .clk_i, .rst_ni, .valid_i(v_prod),
    .a_i(fisr_pkg::THREE_HALVES_BITS), .b_i(prod), .valid_o(v_diff), .d_o(diff)
  );

  fisr_fmul u_y (
    .clk_i, .rst_ni, .valid_i(v_diff),
    .a_i(diff), .b_i(pipe_q[3*Op-1].y), .valid_o(v_y), .p_o(y_new)
  );

  assign valid_o     = v_y;
  assign item_o.x    = pipe_q[Lat-1].x;
  assign item_o.half = pipe_q[Lat-1].half;
  assign item_o.y    = y_new;

endmodule

`default_nettype wire

// ----- rtl/fast_inverse_sqrt_root.sv -----
// Top level: fully pipelined approximate square root via an inverse square root seed.
//
// Takes one IEEE single operand per cycle whenever start is high (busy is never raised)
// and returns x times the refined inverse square root estimate of x, with
// 0x5F3759DF - (x >> 1) as seed and NEWTON_STEPS Newton refinements. Every float
// operation rounds to nearest even with full subnormal and special value handling; any
// NaN result comes out as 0x7FC00000. Each operand passes through a chain of three-stage
// float operators: the halving multiply, four operators per refinement and the final
// multiply. done_o pulses for one cycle with root_bits_o; the receiver cannot stall, so
// results are never held back.
`default_nettype none

module fast_inverse_sqrt_root #(
  parameter int unsigned NEWTON_STEPS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] value_bits_i,
  output logic             done_o,
  output logic [31:0]      root_bits_o
);

  localparam int unsigned Op = fisr_pkg::OP_LAT;

  assign busy = 1'b0;

  // Front end: seed from the bit pattern, halving multiply in parallel
  logic [31:0] seed;
  assign seed = fisr_pkg::SEED_MAGIC - {1'b0, value_bits_i[31:1]};

  logic [63:0] front_q [Op];

  always_ff @(posedge clk_i) begin
    front_q[0] <= {value_bits_i, seed};
    for (int i = 1; i < Op; i++) begin
      front_q[i] <= front_q[i-1];
    end
  end

  logic        v_half;
  logic [31:0] half;

  fisr_fmul u_half (
    .clk_i, .rst_ni, .valid_i(start),
    .a_i(value_bits_i), .b_i(fisr_pkg::HALF_BITS), .valid_o(v_half), .p_o(half)
  );

  // Newton refinement chain
  logic            v_s [NEWTON_STEPS+1];
  fisr_pkg::item_t it_s [NEWTON_STEPS+1];

  assign v_s[0]       = v_half;
  assign it_s[0].x    = front_q[Op-1][63:32];
  assign it_s[0].half = half;
  assign it_s[0].y    = front_q[Op-1][31:0];

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    fisr_step u_step (
      .clk_i, .rst_ni, .valid_i(v_s[k]), .item_i(it_s[k]),
      .valid_o(v_s[k+1]), .item_o(it_s[k+1])
    );
  end

  // Final multiply x * y
  fisr_fmul u_root (
    .clk_i, .rst_ni, .valid_i(v_s[NEWTON_STEPS]),
    .a_i(it_s[NEWTON_STEPS].x), .b_i(it_s[NEWTON_STEPS].y),
    .valid_o(done_o), .p_o(root_bits_o)
  );

endmodule

`default_nettype wire
